/* hw/rtl/ezb_pkg.sv */
// Shared constants and the quarter-wave sine table generator for the ZYX basis rotator.
package ezb_pkg;

    localparam int ANGLE_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 14;

    // pi/2 in Q30, truncated
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    // sin(k*pi/(2Q)) in FRAC_BITS fraction bits, Q = 2^qbits, by Taylor series in Q30
    function automatic longint quarter_entry(input int unsigned k, input int qbits,
                                             input int frac);
        longint unsigned kk;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          one;
        int              shift;
        kk  = longint'(k);
        one = longint'(1) << frac;
        if (kk >= (longint'(1) << qbits)) begin
            return one;
        end
        x    = (kk * PI_HALF_Q30) >> qbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 210;
        sum  = sum - longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        shift = 30 - frac;
        if (shift > 0) begin
            sum = (sum + (longint'(1) << (shift - 1))) >>> shift;
        end
        if (sum > one) begin
            sum = one;
        end
        return sum;
    endfunction

endpackage

/* hw/rtl/ezb_sincos.sv */
// Sine and cosine lookup of one binary angle from a quarter-wave table, registered read.
module ezb_sincos #(
    parameter int ANGLE_BITS = ezb_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = ezb_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic [FRAC_BITS:0]    sin_mag,
    output logic                  sin_neg,
    output logic [FRAC_BITS:0]    cos_mag,
    output logic                  cos_neg
);

    localparam int QBITS = ANGLE_BITS - 2;
    localparam int QLEN  = 1 << QBITS;
    localparam int MAG_W = FRAC_BITS + 1;

    logic [MAG_W-1:0] qtab [QLEN+1];

    for (genvar k = 0; k <= QLEN; k++) begin : g_tab
        assign qtab[k] = MAG_W'(ezb_pkg::quarter_entry(k, QBITS, FRAC_BITS));
    end

    logic [QBITS-1:0] frac_idx;
    logic [1:0]       sin_quad;
    logic [1:0]       cos_quad;
    logic [QBITS:0]   sin_addr;
    logic [QBITS:0]   cos_addr;
    logic [MAG_W-1:0] sin_mag_reg;
    logic             sin_neg_reg;
    logic [MAG_W-1:0] cos_mag_reg;
    logic             cos_neg_reg;

    // cos(a) = sin(a + quarter turn): next quadrant, same offset
    assign frac_idx = angle[QBITS-1:0];
    assign sin_quad = angle[ANGLE_BITS-1 -: 2];
    assign cos_quad = sin_quad + 2'd1;

    // odd quadrants mirror the table
    assign sin_addr = sin_quad[0] ? ((QBITS+1)'(QLEN) - {1'b0, frac_idx}) : {1'b0, frac_idx};
    assign cos_addr = cos_quad[0] ? ((QBITS+1)'(QLEN) - {1'b0, frac_idx}) : {1'b0, frac_idx};

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_mag_reg <= qtab[sin_addr];
            sin_neg_reg <= sin_quad[1];
            cos_mag_reg <= qtab[cos_addr];
            cos_neg_reg <= cos_quad[1];
        end
    end

    assign sin_mag = sin_mag_reg;
    assign sin_neg = sin_neg_reg;
    assign cos_mag = cos_mag_reg;
    assign cos_neg = cos_neg_reg;

endmodule

/* hw/rtl/euler_zyx_basis_vectors.sv */
// Top level of the ZYX Euler basis rotator: streaming pipeline from angles to rotated vectors.
//
// Takes angles about x, y and z as binary angles (2^ANGLE_BITS is one turn) and returns
// the up (0,1,0) and forward (0,0,1) unit vectors rotated about z, then y, then x, as
// signed fixed point with FRAC_BITS fraction bits, the up y and z sums saturated to plus
// or minus one. A seven-stage pipeline (table read, sign, product, round, product, round,
// sum and output register) takes one transaction every cycle while no held output stalls
// the input. Each stage advances on its own, so a held output only stalls the input once
// every stage is occupied.
module euler_zyx_basis_vectors #(
    parameter int ANGLE_BITS = ezb_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = ezb_pkg::FRAC_BITS_DEF,
    localparam int VAL_W     = FRAC_BITS + 2,
    localparam int S_DATA_W  = ((3 * ANGLE_BITS + 7) / 8) * 8,
    localparam int M_DATA_W  = ((6 * VAL_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // angle_x, angle_y, angle_z
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // up_x, up_y, up_z, fwd_x, fwd_y, fwd_z
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int MAG_W  = FRAC_BITS + 1;
    localparam int PROD_W = 2 * VAL_W;
    localparam int NSTAGE = 7;

    localparam logic [PROD_W-1:0]       RND_POS = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [PROD_W-1:0]       RND_NEG = RND_POS - PROD_W'(1);
    localparam logic signed [VAL_W:0]   ONE_W   = (VAL_W+1)'(1) << FRAC_BITS;
    localparam logic signed [VAL_W-1:0] ONE_V   = VAL_W'(1) << FRAC_BITS;

    // axis slots
    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    // first product round
    localparam int P_SZCY = 0;
    localparam int P_SZSY = 1;
    localparam int P_CYSX = 2;
    localparam int P_CYCX = 3;
    localparam int P_CZCX = 4;
    localparam int P_CZSX = 5;

    // output fields
    localparam int O_UPX  = 0;
    localparam int O_UPY  = 1;
    localparam int O_UPZ  = 2;
    localparam int O_FWDX = 3;
    localparam int O_FWDY = 4;
    localparam int O_FWDZ = 5;

    function automatic logic signed [VAL_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + $signed(p[PROD_W-1] ? RND_NEG : RND_POS);
        return VAL_W'(t >>> FRAC_BITS);
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_one(input logic signed [VAL_W:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > ONE_W) begin
            r = ONE_V;
        end else if (v < -ONE_W) begin
            r = -ONE_V;
        end else begin
            r = VAL_W'(v);
        end
        return r;
    endfunction

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [NSTAGE-1:0] adv;

    always_comb begin
        adv[NSTAGE-1] = !vld_reg[NSTAGE-1] || m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NSTAGE; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NSTAGE-1];

    // stage 1: table read
    logic [MAG_W-1:0] s1_sin_mag [3];
    logic             s1_sin_neg [3];
    logic [MAG_W-1:0] s1_cos_mag [3];
    logic             s1_cos_neg [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        ezb_sincos #(
            .ANGLE_BITS (ANGLE_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_sincos (
            .aclk    (aclk),
            .en      (adv[0]),
            .angle   (s_tdata[a*ANGLE_BITS +: ANGLE_BITS]),
            .sin_mag (s1_sin_mag[a]),
            .sin_neg (s1_sin_neg[a]),
            .cos_mag (s1_cos_mag[a]),
            .cos_neg (s1_cos_neg[a])
        );
    end

    // stage 2: apply sign
    logic signed [VAL_W-1:0] s2_sin_reg [3];
    logic signed [VAL_W-1:0] s2_cos_reg [3];

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            for (int a = 0; a < 3; a++) begin
                s2_sin_reg[a] <= s1_sin_neg[a] ? -$signed({1'b0, s1_sin_mag[a]})
                                               :  $signed({1'b0, s1_sin_mag[a]});
                s2_cos_reg[a] <= s1_cos_neg[a] ? -$signed({1'b0, s1_cos_mag[a]})
                                               :  $signed({1'b0, s1_cos_mag[a]});
            end
        end
    end

    // stage 3: first products
    logic signed [PROD_W-1:0] s3_prod_reg [6];
    logic signed [VAL_W-1:0]  s3_sx_reg;
    logic signed [VAL_W-1:0]  s3_cx_reg;
    logic signed [VAL_W-1:0]  s3_sy_reg;

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            s3_prod_reg[P_SZCY] <= s2_sin_reg[AX_Z] * s2_cos_reg[AX_Y];
            s3_prod_reg[P_SZSY] <= s2_sin_reg[AX_Z] * s2_sin_reg[AX_Y];
            s3_prod_reg[P_CYSX] <= s2_cos_reg[AX_Y] * s2_sin_reg[AX_X];
            s3_prod_reg[P_CYCX] <= s2_cos_reg[AX_Y] * s2_cos_reg[AX_X];
            s3_prod_reg[P_CZCX] <= s2_cos_reg[AX_Z] * s2_cos_reg[AX_X];
            s3_prod_reg[P_CZSX] <= s2_cos_reg[AX_Z] * s2_sin_reg[AX_X];
            s3_sx_reg           <= s2_sin_reg[AX_X];
            s3_cx_reg           <= s2_cos_reg[AX_X];
            s3_sy_reg           <= s2_sin_reg[AX_Y];
        end
    end

    // stage 4: round
    logic signed [VAL_W-1:0] s4_rnd_reg [6];
    logic signed [VAL_W-1:0] s4_sx_reg;
    logic signed [VAL_W-1:0] s4_cx_reg;
    logic signed [VAL_W-1:0] s4_sy_reg;

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            for (int p = 0; p < 6; p++) begin
                s4_rnd_reg[p] <= round_prod(s3_prod_reg[p]);
            end
            s4_sx_reg <= s3_sx_reg;
            s4_cx_reg <= s3_cx_reg;
            s4_sy_reg <= s3_sy_reg;
        end
    end

    // stage 5: second products on the rotated up z term
    logic signed [PROD_W-1:0] s5_ps_reg;
    logic signed [PROD_W-1:0] s5_pc_reg;
    logic signed [VAL_W-1:0]  s5_rnd_reg [6];
    logic signed [VAL_W-1:0]  s5_sy_reg;

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            s5_ps_reg  <= s4_rnd_reg[P_SZSY] * s4_sx_reg;
            s5_pc_reg  <= s4_rnd_reg[P_SZSY] * s4_cx_reg;
            s5_rnd_reg <= s4_rnd_reg;
            s5_sy_reg  <= s4_sy_reg;
        end
    end

    // stage 6: round
    logic signed [VAL_W-1:0] s6_rs_reg;
    logic signed [VAL_W-1:0] s6_rc_reg;
    logic signed [VAL_W-1:0] s6_rnd_reg [6];
    logic signed [VAL_W-1:0] s6_sy_reg;

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            s6_rs_reg  <= round_prod(s5_ps_reg);
            s6_rc_reg  <= round_prod(s5_pc_reg);
            s6_rnd_reg <= s5_rnd_reg;
            s6_sy_reg  <= s5_sy_reg;
        end
    end

    // stage 7: sum, saturate, hold for the output transaction
    logic signed [VAL_W:0]   s7_upy_sum;
    logic signed [VAL_W:0]   s7_upz_sum;
    logic signed [VAL_W-1:0] out_reg [6];

    assign s7_upy_sum = {s6_rnd_reg[P_CZCX][VAL_W-1], s6_rnd_reg[P_CZCX]}
                      - {s6_rs_reg[VAL_W-1], s6_rs_reg};
    assign s7_upz_sum = {s6_rnd_reg[P_CZSX][VAL_W-1], s6_rnd_reg[P_CZSX]}
                      + {s6_rc_reg[VAL_W-1], s6_rc_reg};

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            out_reg[O_UPX]  <= -s6_rnd_reg[P_SZCY];
            out_reg[O_UPY]  <= sat_one(s7_upy_sum);
            out_reg[O_UPZ]  <= sat_one(s7_upz_sum);
            out_reg[O_FWDX] <= s6_sy_reg;
            out_reg[O_FWDY] <= -s6_rnd_reg[P_CYSX];
            out_reg[O_FWDZ] <= s6_rnd_reg[P_CYCX];
        end
    end

    assign m_tdata = M_DATA_W'({out_reg[O_FWDZ], out_reg[O_FWDY], out_reg[O_FWDX],
                                out_reg[O_UPZ], out_reg[O_UPY], out_reg[O_UPX]});

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output stage");

    a_refill_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NSTAGE-2] && adv[NSTAGE-1]) |=> m_tvalid)
        else $error("transaction lost between last two stages");

    a_up_y_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg[O_UPY] <= ONE_V && out_reg[O_UPY] >= -ONE_V))
        else $error("up_y outside saturation range");

    a_up_z_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg[O_UPZ] <= ONE_V && out_reg[O_UPZ] >= -ONE_V))
        else $error("up_z outside saturation range");

endmodule

/* tb/euler_zyx_basis_vectors_tb.sv */
// Self-checking testbench for the ZYX Euler basis rotator: directed and random angles, idling, stalls, field checks.
module euler_zyx_basis_vectors_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ABITS = ezb_pkg::ANGLE_BITS_DEF;
    localparam int FRAC  = ezb_pkg::FRAC_BITS_DEF;
    localparam int VAL_W = FRAC + 2;
    localparam int QB    = ABITS - 2;
    localparam int QN    = 1 << QB;
    localparam int S_W   = ((3 * ABITS + 7) / 8) * 8;
    localparam int M_W   = ((6 * VAL_W + 7) / 8) * 8;
    localparam longint UNIT = longint'(1) << FRAC;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int LIMIT = 400000;

    typedef logic [3*ABITS-1:0] angles_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] fwd_z;
        logic signed [VAL_W-1:0] fwd_y;
        logic signed [VAL_W-1:0] fwd_x;
        logic signed [VAL_W-1:0] up_z;
        logic signed [VAL_W-1:0] up_y;
        logic signed [VAL_W-1:0] up_x;
    } basis_t;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } vec_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    euler_zyx_basis_vectors u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    longint  quarter_sine [0:QN];
    angles_t angle_q [$];
    basis_t  expected_basis_q [$];
    int      issued       = 0;
    int      accepted     = 0;
    int      mismatches   = 0;
    int      cycles       = 0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;
    bit      in_taken     = 1'b0;
    string   field_names [6] = '{"up_x", "up_y", "up_z", "fwd_x", "fwd_y", "fwd_z"};

    function automatic void build_quarter_sine();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        for (int k = 0; k <= QN; k++) begin
            if (k == QN) begin
                quarter_sine[k] = UNIT;
            end else begin
                x    = (longint'(k) * HALF_PI_Q30) >> QB;
                x2   = (x * x) >> 30;
                term = x;
                acc  = longint'(x);
                for (int n = 1; n <= 7; n++) begin
                    term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        acc = acc - longint'(term);
                    end else begin
                        acc = acc + longint'(term);
                    end
                end
                if (acc < 0) begin
                    acc = 0;
                end
                if (30 - FRAC > 0) begin
                    acc = (acc + (longint'(1) << (30 - FRAC - 1))) >>> (30 - FRAC);
                end
                quarter_sine[k] = (acc > UNIT) ? UNIT : acc;
            end
        end
    endfunction

    function automatic longint sin_of(input logic [ABITS-1:0] a);
        int idx;
        idx = int'(a[QB-1:0]);
        case (a[ABITS-1 -: 2])
            2'd0:    return quarter_sine[idx];
            2'd1:    return quarter_sine[QN - idx];
            2'd2:    return -quarter_sine[idx];
            default: return -quarter_sine[QN - idx];
        endcase
    endfunction

    function automatic longint cos_of(input logic [ABITS-1:0] a);
        logic [ABITS-1:0] b;
        b = ABITS'(a + QN);
        return sin_of(b);
    endfunction

    // round half away from zero
    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = (m + (longint'(1) << (FRAC - 1))) >>> FRAC;
        return (p < 0) ? -m : m;
    endfunction

    function automatic longint sat_unit(input longint v);
        if (v > UNIT) begin
            return UNIT;
        end
        if (v < -UNIT) begin
            return -UNIT;
        end
        return v;
    endfunction

    function automatic vec_t rotate_zyx(input vec_t v, input longint sx, input longint cx,
                                        input longint sy, input longint cy,
                                        input longint sz, input longint cz);
        vec_t a;
        vec_t b;
        vec_t c;
        a.x = sat_unit(fx_mul(v.x, cz) - fx_mul(v.y, sz));
        a.y = sat_unit(fx_mul(v.x, sz) + fx_mul(v.y, cz));
        a.z = v.z;
        b.x = sat_unit(fx_mul(a.x, cy) + fx_mul(a.z, sy));
        b.y = a.y;
        b.z = sat_unit(fx_mul(a.z, cy) - fx_mul(a.x, sy));
        c.x = b.x;
        c.y = sat_unit(fx_mul(b.y, cx) - fx_mul(b.z, sx));
        c.z = sat_unit(fx_mul(b.y, sx) + fx_mul(b.z, cx));
        return c;
    endfunction

    function automatic basis_t rotate_basis(input angles_t ang);
        longint sx;
        longint cx;
        longint sy;
        longint cy;
        longint sz;
        longint cz;
        vec_t   up;
        vec_t   fwd;
        basis_t r;
        sx  = sin_of(ang[ABITS-1:0]);
        cx  = cos_of(ang[ABITS-1:0]);
        sy  = sin_of(ang[2*ABITS-1:ABITS]);
        cy  = cos_of(ang[2*ABITS-1:ABITS]);
        sz  = sin_of(ang[3*ABITS-1:2*ABITS]);
        cz  = cos_of(ang[3*ABITS-1:2*ABITS]);
        up  = '{0, UNIT, 0};
        fwd = '{0, 0, UNIT};
        up  = rotate_zyx(up, sx, cx, sy, cy, sz, cz);
        fwd = rotate_zyx(fwd, sx, cx, sy, cy, sz, cz);
        r.up_x  = VAL_W'(up.x);
        r.up_y  = VAL_W'(up.y);
        r.up_z  = VAL_W'(up.z);
        r.fwd_x = VAL_W'(fwd.x);
        r.fwd_y = VAL_W'(fwd.y);
        r.fwd_z = VAL_W'(fwd.z);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
        mismatches++;
    endtask

    // drive the angle stream and the result back-pressure
    always @(negedge aclk) begin
        logic [S_W-1:0] word;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || in_taken) begin
                if (angle_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    word = '0;
                    word[3*ABITS-1:0] = angle_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= word;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // predict on each accepted transaction, check each delivered one
    always @(posedge aclk) begin
        basis_t got;
        basis_t want;
        if (aresetn) begin
            cycles++;
            if (cycles > LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                in_taken = s_tvalid && s_tready;
                if (in_taken) begin
                    expected_basis_q.push_back(rotate_basis(s_tdata[3*ABITS-1:0]));
                    accepted++;
                end
                if (m_tvalid && m_tready) begin
                    got = basis_t'(m_tdata[6*VAL_W-1:0]);
                    if (expected_basis_q.size() == 0) begin
                        report_mismatch("unexpected transaction up_x", got.up_x, 0);
                    end else begin
                        want = expected_basis_q.pop_front();
                        for (int k = 0; k < 6; k++) begin
                            if (got[k*VAL_W +: VAL_W] !== want[k*VAL_W +: VAL_W]) begin
                                report_mismatch(field_names[k],
                                                $signed(got[k*VAL_W +: VAL_W]),
                                                $signed(want[k*VAL_W +: VAL_W]));
                            end
                        end
                    end
                end
            end
        end
    end

    task automatic queue_angles(input int ax, input int ay, input int az);
        angle_q.push_back({ABITS'(az), ABITS'(ay), ABITS'(ax)});
        issued++;
    endtask

    function automatic int pick_angle();
        case ($urandom_range(3))
            0:       return $urandom_range(QN * 4 - 1);
            1:       return ($urandom_range(7) * (QN / 2) + $urandom_range(6) - 3) & (QN * 4 - 1);
            2:       return $urandom_range(1) ? 0 : QN * 4 - 1;
            default: return $urandom_range(QN * 4 - 1);
        endcase
    endfunction

    task automatic drain();
        while (accepted != issued || expected_basis_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int n = 0; n < count; n++) begin
            queue_angles(pick_angle(), pick_angle(), pick_angle());
        end
        // hold further stimulus until every result is back
        drain();
    endtask

    initial begin
        build_quarter_sine();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        queue_angles(0, 0, 0);
        queue_angles(4095, 4095, 4095);
        queue_angles(1024, 0, 0);
        queue_angles(0, 1024, 0);
        queue_angles(0, 0, 1024);
        queue_angles(2048, 2048, 2048);
        queue_angles(3072, 3072, 3072);
        queue_angles(1023, 1025, 2047);
        queue_angles(2049, 3071, 1);
        queue_angles(4095, 0, 0);
        queue_angles(0, 4095, 0);
        queue_angles(0, 0, 4095);
        queue_angles(1, 1, 1);
        queue_angles(512, 512, 512);
        queue_angles(1536, 2560, 3584);
        queue_angles(3584, 3584, 3584);
        queue_angles(512, 0, 512);
        queue_angles(0, 512, 512);
        queue_angles(512, 512, 0);
        queue_angles(2560, 1536, 512);
        queue_angles(3072, 1024, 2048);
        queue_angles(2730, 1365, 341);
        queue_angles(4000, 96, 2222);
        queue_angles(2047, 2049, 3073);
        drain();

        run_phase(0, 0, 400);
        run_phase(58, 0, 450);
        run_phase(0, 58, 450);
        run_phase(21, 21, 450);

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_basis_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
